// ===== hw/rtl/ihs_pkg.sv =====
package ihs_pkg;

  localparam int unsigned SAMPLE_W          = 8;
  localparam int unsigned ROW_WIDTH_W       = 13;
  localparam int unsigned COMP_COUNT_W      = 3;
  localparam int unsigned CFG_IDX_W         = 1;
  localparam int unsigned CFG_DATA_W        = 13;
  localparam int unsigned DEF_MAX_WIDTH     = 4096;
  localparam int unsigned DEF_MAX_COMPONENTS = 4;
  localparam int unsigned FIFO_DEPTH        = 4;

  localparam logic [ROW_WIDTH_W-1:0]  RESET_ROW_WIDTH  = 13'd256;
  localparam logic [COMP_COUNT_W-1:0] RESET_COMP_COUNT = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_WIDTH       = 1'b0,
    CFG_COMPONENT_COUNT = 1'b1
  } ihs_cfg_idx_e;

  // line store access issued by the front stage
  typedef struct packed {
    logic wr;
    logic rd;
    logic eor;
  } ihs_op_t;

endpackage

// ===== hw/rtl/ihs_in_if.sv =====
interface ihs_in_if
  import ihs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                start_of_frame;

  modport source (output valid, sample, start_of_frame, input ready);
  modport sink   (input valid, sample, start_of_frame, output ready);
endinterface

// ===== hw/rtl/ihs_out_if.sv =====
interface ihs_out_if
  import ihs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] scaled_sample;
  logic                end_of_row;

  modport source (output valid, scaled_sample, end_of_row, input ready);
  modport sink   (input valid, scaled_sample, end_of_row, output ready);
endinterface

// ===== hw/rtl/ihs_front.sv =====
module ihs_front
  import ihs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH      = DEF_MAX_WIDTH,
  parameter int unsigned MAX_COMPONENTS = DEF_MAX_COMPONENTS,
  localparam int unsigned DEPTH = MAX_WIDTH / 2 * MAX_COMPONENTS,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    acc_i,
  input  logic [SAMPLE_W-1:0]     sample_i,
  input  logic                    sof_i,
  input  logic [ROW_WIDTH_W-1:0]  row_width_i,
  input  logic [COMP_COUNT_W-1:0] comp_count_i,
  output ihs_op_t                 op_o,
  output logic [AW-1:0]           idx_o,
  output logic [SAMPLE_W-1:0]     avg_o
);

  localparam int unsigned CPW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int unsigned CLW = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EW  = (WW > ROW_WIDTH_W) ? WW : ROW_WIDTH_W;

  logic [CLW-1:0]          col_q, col_d, col1;
  logic [CPW-1:0]          comp_q, comp_d, comp1;
  logic                    ph_q, ph_d, ph1;
  logic                    par_q, par_d, par1;
  logic [SAMPLE_W-1:0]     hold_q [MAX_COMPONENTS];

  logic [EW-1:0]           w_clip;
  logic [WW-1:0]           w_eff, col_inc;
  logic [COMP_COUNT_W-1:0] c_eff, comp_inc;
  logic [SAMPLE_W:0]       pair_sum;
  logic [AW-1:0]           half_col, idx;

  ihs_op_t                 op_d, op_q;
  logic [AW-1:0]           idx_q;
  logic [SAMPLE_W-1:0]     avg_q;

  always_comb begin
    w_clip = EW'(row_width_i);
    if (w_clip > EW'(MAX_WIDTH)) begin
      w_clip = EW'(MAX_WIDTH);
    end
    w_clip[0] = 1'b0;
    w_eff = (w_clip < EW'(2)) ? WW'(2) : WW'(w_clip);

    c_eff = comp_count_i;
    if (c_eff == '0) begin
      c_eff = COMP_COUNT_W'(1);
    end else if (c_eff > COMP_COUNT_W'(MAX_COMPONENTS)) begin
      c_eff = COMP_COUNT_W'(MAX_COMPONENTS);
    end
  end

  always_comb begin
    col1 = sof_i ? '0 : col_q;
    comp1 = sof_i ? '0 : comp_q;
    ph1  = sof_i ? 1'b0 : ph_q;
    par1 = sof_i ? 1'b0 : par_q;
    if (WW'(col1) >= w_eff) begin
      col1 = '0;
      ph1  = 1'b0;
    end
    if (COMP_COUNT_W'(comp1) >= c_eff) begin
      comp1 = '0;
    end

    pair_sum = {1'b0, hold_q[comp1]} + {1'b0, sample_i};
    half_col = AW'(col1 >> 1);
    idx      = AW'(half_col * AW'(c_eff)) + AW'(comp1);

    op_d.wr  = ph1 && !par1;
    op_d.rd  = ph1 && par1;
    op_d.eor = (WW'(col1) == w_eff - WW'(1)) &&
               (COMP_COUNT_W'(comp1) == c_eff - COMP_COUNT_W'(1));

    col_d    = col1;
    comp_d   = comp1;
    ph_d     = ph1;
    par_d    = par1;
    col_inc  = WW'(col1) + WW'(1);
    comp_inc = COMP_COUNT_W'(comp1) + COMP_COUNT_W'(1);
    if (comp_inc >= c_eff) begin
      comp_d = '0;
      col_d  = CLW'(col_inc);
      ph_d   = !ph1;
      if (col_inc >= w_eff) begin
        col_d = '0;
        ph_d  = 1'b0;
        par_d = !par1;
      end
    end else begin
      comp_d = CPW'(comp_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      comp_q <= '0;
      ph_q   <= 1'b0;
      par_q  <= 1'b0;
      op_q   <= '0;
    end else begin
      if (acc_i) begin
        col_q  <= col_d;
        comp_q <= comp_d;
        ph_q   <= ph_d;
        par_q  <= par_d;
        op_q   <= op_d;
      end else begin
        op_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && !ph1) begin
      hold_q[comp1] <= sample_i;
    end
    if (acc_i) begin
      idx_q <= idx;
      avg_q <= pair_sum[SAMPLE_W:1];
    end
  end

  assign op_o  = op_q;
  assign idx_o = idx_q;
  assign avg_o = avg_q;

endmodule

// ===== hw/rtl/ihs_line_store.sv =====
module ihs_line_store
  import ihs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH      = DEF_MAX_WIDTH,
  parameter int unsigned MAX_COMPONENTS = DEF_MAX_COMPONENTS,
  localparam int unsigned DEPTH = MAX_WIDTH / 2 * MAX_COMPONENTS,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ihs_op_t             op_i,
  input  logic [AW-1:0]       idx_i,
  input  logic [SAMPLE_W-1:0] avg_i,
  output logic                push_o,
  output logic [SAMPLE_W-1:0] data_o,
  output logic                eor_o
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;
  logic [SAMPLE_W-1:0] avg_q;
  logic                valid_q;
  logic                eor_q;
  logic [SAMPLE_W:0]   sum;

  // upper row written on even rows, read back one row later
  always_ff @(posedge clk_i) begin
    if (op_i.wr) begin
      mem[idx_i] <= avg_i;
    end
    if (op_i.rd) begin
      rdata_q <= mem[idx_i];
      avg_q   <= avg_i;
      eor_q   <= op_i.eor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= op_i.rd;
    end
  end

  assign sum    = {1'b0, rdata_q} + {1'b0, avg_q};
  assign push_o = valid_q;
  assign data_o = sum[SAMPLE_W:1];
  assign eor_o  = eor_q;

endmodule

// ===== hw/rtl/ihs_out_fifo.sv =====
module ihs_out_fifo
  import ihs_pkg::*;
#(
  localparam int unsigned PW  = $clog2(FIFO_DEPTH),
  localparam int unsigned CNW = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [SAMPLE_W-1:0] data_i,
  input  logic                eor_i,
  output logic [CNW-1:0]      count_o,
  ihs_out_if.source           out_o
);

  logic [SAMPLE_W-1:0] data_q [FIFO_DEPTH];
  logic                eor_q  [FIFO_DEPTH];
  logic [PW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CNW-1:0]      cnt_q, cnt_d;
  logic                pop;

  assign pop = out_o.valid && out_o.ready;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + CNW'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - CNW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= data_i;
      eor_q[wr_ptr_q]  <= eor_i;
    end
  end

  assign out_o.valid         = (cnt_q != '0);
  assign out_o.scaled_sample = data_q[rd_ptr_q];
  assign out_o.end_of_row    = eor_q[rd_ptr_q];
  assign count_o             = cnt_q;

endmodule

// ===== hw/rtl/image_half_scale_box_filter.sv =====
// A result passes through the front register, the line store read and the output queue
// after the request that completes its 2x2 block.
// Throughput: one request per cycle sustained; the line store takes one access per cycle.
// Requests stall only when the 4-entry output queue and the results in flight fill it.
// Reset clears positions, queue and configuration (row_width 256, component_count 4);
// line store contents stay undefined until written.
module image_half_scale_box_filter
  import ihs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH      = DEF_MAX_WIDTH,
  parameter int unsigned MAX_COMPONENTS = DEF_MAX_COMPONENTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ihs_in_if.sink                in_i,
  ihs_out_if.source             out_o
);

  localparam int unsigned DEPTH = MAX_WIDTH / 2 * MAX_COMPONENTS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNW   = $clog2(FIFO_DEPTH + 1);

  logic [ROW_WIDTH_W-1:0]  row_width_q;
  logic [COMP_COUNT_W-1:0] comp_count_q;
  logic                    acc;
  ihs_op_t                 op;
  logic [AW-1:0]           idx;
  logic [SAMPLE_W-1:0]     avg, res_data;
  logic                    res_push, res_eor;
  logic [CNW-1:0]          fifo_cnt;
  logic [CNW:0]            pending;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q  <= RESET_ROW_WIDTH;
      comp_count_q <= RESET_COMP_COUNT;
    end else if (cfg_we_i) begin
      unique case (ihs_cfg_idx_e'(cfg_idx_i))
        CFG_ROW_WIDTH:       row_width_q  <= cfg_data_i[ROW_WIDTH_W-1:0];
        CFG_COMPONENT_COUNT: comp_count_q <= cfg_data_i[COMP_COUNT_W-1:0];
      endcase
    end
  end

  // reserve queue space for every result still in the pipe
  assign pending    = (CNW+1)'(fifo_cnt) + (CNW+1)'(op.rd) + (CNW+1)'(res_push);
  assign in_i.ready = (pending < (CNW+1)'(FIFO_DEPTH));
  assign acc        = in_i.valid && in_i.ready;

  ihs_front #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .sample_i     (in_i.sample),
    .sof_i        (in_i.start_of_frame),
    .row_width_i  (row_width_q),
    .comp_count_i (comp_count_q),
    .op_o         (op),
    .idx_o        (idx),
    .avg_o        (avg)
  );

  ihs_line_store #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_line_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .idx_i  (idx),
    .avg_i  (avg),
    .push_o (res_push),
    .data_o (res_data),
    .eor_o  (res_eor)
  );

  ihs_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_data),
    .eor_i   (res_eor),
    .count_o (fifo_cnt),
    .out_o   (out_o)
  );

endmodule

// ===== hw/rtl/ihs_checker.sv =====
module ihs_checker
  import ihs_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [SAMPLE_W-1:0] out_data_i,
  input logic                out_eor_i
);

  // a stalled input side always has results waiting to drain
  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_i) |-> out_valid_i)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result present right after reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output request dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(out_data_i) && $stable(out_eor_i)))
    else $error("stalled output changed");

endmodule

bind image_half_scale_box_filter ihs_checker u_ihs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.scaled_sample),
  .out_eor_i   (out_o.end_of_row)
);
